// ===== src/msq_pkg.sv =====
// Shared types, constants and helpers for the melody note sequencer.
// Used by msq_div, the top level and the testbench; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package msq_pkg;

  localparam int NOTE_DEPTH = 256;
  localparam int ADDR_W     = $clog2(NOTE_DEPTH);

  // Request codes.
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_TIME  = 2'd2;
  localparam logic [1:0] REQ_STOP  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TEMPO  = 2'd0;
  localparam logic [1:0] CFG_LENGTH = 2'd1;
  localparam logic [1:0] CFG_LOOP   = 2'd2;

  localparam int CFG_W = 10;

  localparam logic [3:0] REST_CODE = 4'd12;

  // A whole note lasts four beats of 60000 ms / bpm.
  localparam int WHOLE_MS = 60000 * 4;
  localparam int WHOLE_W  = $clog2(WHOLE_MS + 1);
  localparam int DIVD_W   = 23;
  localparam int DIVS_W   = 10;
  localparam int CNT_W    = $clog2(DIVD_W + 1);
  localparam int LEN_W    = 22;
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] now_ms;
    logic [7:0]  entry_index;
    logic [3:0]  pitch_code;
    logic [3:0]  octave_in;
    logic [4:0]  dur_numerator;
    logic [6:0]  dur_denominator;
  } req_t;

  typedef struct packed {
    logic       tone_write;
    logic       tone_silent;
    logic [3:0] pitch_out;
    logic [3:0] octave_out;
    logic       is_playing;
    logic [7:0] note_position;
  } res_t;

  typedef struct packed {
    logic [6:0] den;
    logic [4:0] num;
    logic [3:0] octave;
    logic [3:0] pitch;
  } note_t;

  localparam int ENTRY_W = $bits(note_t);

  // Reduces an 8-bit position to a store address by trial subtraction of
  // shifted copies of the depth, eight narrow steps at most.
  function automatic logic [ADDR_W-1:0] store_addr(input logic [7:0] v);
    int r;
    r = int'(v);
    for (int k = 7; k >= 0; k--) begin
      if (r >= (NOTE_DEPTH << k)) begin
        r = r - (NOTE_DEPTH << k);
      end
    end
    return r[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/msq_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// Standalone; holds the note store of the sequencer.
`timescale 1ns / 1ps
`default_nettype none

module msq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/msq_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
// Depends on msq_pkg for the operand widths.
`timescale 1ns / 1ps
`default_nettype none

module msq_div
  import msq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DIVD_W-1:0] dividend,
  input  wire logic [DIVS_W-1:0] divisor,
  output logic                   done,
  output logic      [DIVD_W-1:0] quotient
);

  logic [DIVS_W-1:0] rem;
  logic [DIVS_W-1:0] dsor;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [DIVS_W:0]   trial;
  logic              fits;

  assign trial = {rem, quotient[DIVD_W-1]};
  assign fits  = trial >= {1'b0, dsor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quotient <= dividend;
        rem      <= '0;
        dsor     <= divisor;
        cnt      <= CNT_W'(DIVD_W);
        busy     <= 1'b1;
      end else if (busy) begin
        if (fits) begin
          rem <= DIVS_W'(trial - {1'b0, dsor});
        end else begin
          rem <= trial[DIVS_W-1:0];
        end
        quotient <= {quotient[DIVD_W-2:0], fits};
        cnt      <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/melody_note_sequencer.sv =====
// Top level of the melody note sequencer: control sequencer, note store
// and length divider. Depends on msq_pkg, msq_ram and msq_div.
//
// Usage: request items enter on req_valid/req_ready, one result item per
// request leaves on res_valid/res_ready. Load items, stop items and time
// items that start no new note go from S_IDLE straight to S_DONE, which
// registers the result once the output register is free. A start item, or
// a time item that begins the next note, reads the entry from the note
// store (registered read, S_READ then S_ENTRY) and then computes the note
// length with the serial divider, used twice (whole-note length in
// S_DIV_WHOLE, then the fraction in S_MUL and S_DIV_LEN) before S_DONE.
// Items are handled one at a time; req_ready is high whenever no item
// is in progress.
// Results sit in an output register, so the next request is taken while a
// result waits for res_ready; a stalled receiver only holds back the item
// after that one. Configuration writes (cfg_write, cfg_index, cfg_data)
// take effect at once. Reset clears playback state and sets tempo 120,
// melody length 1 and looping off; the note store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module melody_note_sequencer
  import msq_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_ready,
  input  wire req_t             req_item,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output res_t                  res_item,
  input  wire logic             cfg_write,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_ENTRY, S_DIV_WHOLE, S_MUL, S_DIV_LEN, S_DONE
  } state_t;

  state_t state;

  logic [9:0]        tempo_bpm;
  logic [8:0]        melody_length;
  logic              loop_enable;

  logic              playing;
  logic [7:0]        position;
  logic [31:0]       start_ms;
  logic [LEN_W-1:0]  length_ms;

  logic              pend_write;
  logic              pend_silent;
  logic [3:0]        pend_pitch;
  logic [3:0]        pend_octave;

  logic [4:0]        ent_num;
  logic [6:0]        ent_den;
  logic [WHOLE_W-1:0] whole;

  logic              div_start;
  logic [DIVD_W-1:0] div_dividend;
  logic [DIVS_W-1:0] div_divisor;
  logic              div_done;
  logic [DIVD_W-1:0] div_quotient;

  logic              accept;
  logic              ram_we;
  note_t             ram_wdata;
  note_t             ram_rdata;
  logic [31:0]       elapsed;
  logic [8:0]        next_pos;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign ram_we    = accept && (req_item.req_type == REQ_LOAD);
  assign ram_wdata = '{den: req_item.dur_denominator, num: req_item.dur_numerator,
                       octave: req_item.octave_in, pitch: req_item.pitch_code};
  assign elapsed   = req_item.now_ms - start_ms;
  assign next_pos  = {1'b0, position} + 9'd1;

  msq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(NOTE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(store_addr(req_item.entry_index)),
    .wdata(ram_wdata),
    .raddr(store_addr(position)),
    .rdata(ram_rdata)
  );

  msq_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .done    (div_done),
    .quotient(div_quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tempo_bpm     <= 10'd120;
      melody_length <= 9'd1;
      loop_enable   <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_TEMPO:  tempo_bpm     <= cfg_data[9:0];
        CFG_LENGTH: melody_length <= cfg_data[8:0];
        CFG_LOOP:   loop_enable   <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      playing   <= 1'b0;
      position  <= '0;
      start_ms  <= '0;
      length_ms <= '0;
      div_start <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            pend_write  <= 1'b0;
            pend_silent <= 1'b0;
            pend_pitch  <= '0;
            pend_octave <= '0;
            state       <= S_DONE;
            case (req_item.req_type)
              REQ_START: begin
                position <= '0;
                playing  <= 1'b1;
                start_ms <= req_item.now_ms;
                state    <= S_READ;
              end
              REQ_TIME: begin
                if (playing && (elapsed >= {{(32 - LEN_W){1'b0}}, length_ms})) begin
                  position <= next_pos[7:0];
                  if (next_pos >= melody_length) begin
                    if (loop_enable) begin
                      position <= '0;
                      start_ms <= req_item.now_ms;
                      state    <= S_READ;
                    end else begin
                      playing     <= 1'b0;
                      pend_write  <= 1'b1;
                      pend_silent <= 1'b1;
                    end
                  end else begin
                    start_ms <= req_item.now_ms;
                    state    <= S_READ;
                  end
                end
              end
              REQ_STOP: begin
                playing     <= 1'b0;
                pend_write  <= 1'b1;
                pend_silent <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        S_READ: begin
          state <= S_ENTRY;
        end
        S_ENTRY: begin
          pend_write <= 1'b1;
          if (ram_rdata.pitch >= REST_CODE) begin
            pend_silent <= 1'b1;
          end else begin
            pend_pitch  <= ram_rdata.pitch;
            pend_octave <= ram_rdata.octave;
          end
          ent_num      <= ram_rdata.num;
          ent_den      <= ram_rdata.den;
          div_dividend <= DIVD_W'(WHOLE_MS);
          div_divisor  <= (tempo_bpm == '0) ? DIVS_W'(1) : tempo_bpm;
          div_start    <= 1'b1;
          state        <= S_DIV_WHOLE;
        end
        S_DIV_WHOLE: begin
          if (div_done) begin
            whole <= div_quotient[WHOLE_W-1:0];
            state <= S_MUL;
          end
        end
        S_MUL: begin
          div_dividend <= DIVD_W'(whole) * DIVD_W'(ent_num);
          div_divisor  <= (ent_den == '0) ? DIVS_W'(1) : DIVS_W'(ent_den);
          div_start    <= 1'b1;
          state        <= S_DIV_LEN;
        end
        S_DIV_LEN: begin
          if (div_done) begin
            if (div_quotient > DIVD_W'(LEN_MAX)) begin
              length_ms <= LEN_MAX;
            end else begin
              length_ms <= div_quotient[LEN_W-1:0];
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!res_valid || res_ready) begin
            res_valid              <= 1'b1;
            res_item.tone_write    <= pend_write;
            res_item.tone_silent   <= pend_silent;
            res_item.pitch_out     <= pend_pitch;
            res_item.octave_out    <= pend_octave;
            res_item.is_playing    <= playing;
            res_item.note_position <= position;
            state                  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== bench/tb_melody_note_sequencer.sv =====
// Self-checking testbench for melody_note_sequencer: note loads, start, stop
// and time items against an in-bench prediction of playback, with random idling.
// Depends on msq_pkg and the melody_note_sequencer RTL.
`timescale 1ns / 1ps

module tb_melody_note_sequencer;
  import msq_pkg::*;

  localparam int LIMIT        = 1_000_000;
  localparam int MAX_SHOWN    = 10;
  localparam int DRAIN_CYCLES = 60;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_ready;
  req_t             req_item  = '0;
  logic             res_valid;
  logic             res_ready = 1'b0;
  res_t             res_item;
  logic             cfg_write = 1'b0;
  logic [1:0]       cfg_index = CFG_TEMPO;
  logic [CFG_W-1:0] cfg_data  = '0;

  melody_note_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_item  (req_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow of the playback state and the registers.
  note_t            song_mem    [NOTE_DEPTH];
  bit               song_loaded [NOTE_DEPTH];
  bit               playing  = 1'b0;
  logic [7:0]       play_pos = '0;
  logic [31:0]      note_t0  = '0;
  logic [LEN_W-1:0] note_len = '0;
  logic [9:0]       tempo    = 10'd120;
  logic [8:0]       song_len = 9'd1;
  logic             looping  = 1'b0;

  req_t pending_items [$];
  res_t melody_exp    [$];

  int unsigned cycle_count = 0;
  int failures = 0;
  int checked  = 0;
  int sent     = 0;
  int loads    = 0;
  int starts   = 0;
  int advances = 0;
  int song_ends = 0;
  int settings = 1;

  function automatic logic [LEN_W-1:0] length_ms(note_t n);
    longint unsigned bpm, den, ms;
    bpm = (tempo == 0) ? 1 : tempo;
    den = (n.den == 0) ? 1 : n.den;
    ms = ((WHOLE_MS / bpm) * n.num) / den;
    return (ms > LEN_MAX) ? LEN_MAX : ms[LEN_W-1:0];
  endfunction

  function automatic res_t start_note(logic [31:0] at_ms);
    note_t n;
    res_t  r;
    n = song_mem[int'(play_pos) % NOTE_DEPTH];
    r = '0;
    r.tone_write = 1'b1;
    if (n.pitch >= REST_CODE) begin
      r.tone_silent = 1'b1;
    end else begin
      r.pitch_out  = n.pitch;
      r.octave_out = n.octave;
    end
    note_len = length_ms(n);
    note_t0  = at_ms;
    return r;
  endfunction

  function automatic res_t silence();
    res_t r;
    r = '0;
    playing = 1'b0;
    r.tone_write  = 1'b1;
    r.tone_silent = 1'b1;
    return r;
  endfunction

  function automatic res_t predict(req_t it);
    res_t        r;
    note_t       n;
    logic [31:0] elapsed;
    int          nxt;
    r = '0;
    case (it.req_type)
      REQ_LOAD: begin
        n.pitch  = it.pitch_code;
        n.octave = it.octave_in;
        n.num    = it.dur_numerator;
        n.den    = it.dur_denominator;
        song_mem[int'(it.entry_index) % NOTE_DEPTH] = n;
        song_loaded[int'(it.entry_index) % NOTE_DEPTH] = 1'b1;
        loads++;
      end
      REQ_START: begin
        play_pos = '0;
        playing  = 1'b1;
        r = start_note(it.now_ms);
        starts++;
      end
      REQ_TIME: begin
        elapsed = it.now_ms - note_t0;
        if (playing && elapsed >= {10'd0, note_len}) begin
          nxt = int'(play_pos) + 1;
          play_pos = play_pos + 8'd1;
          advances++;
          if (nxt >= int'(song_len)) begin
            song_ends++;
            if (looping) begin
              play_pos = '0;
              r = start_note(it.now_ms);
            end else begin
              r = silence();
            end
          end else begin
            r = start_note(it.now_ms);
          end
        end
      end
      REQ_STOP: r = silence();
    endcase
    r.is_playing    = playing;
    r.note_position = play_pos;
    return r;
  endfunction

  // Store slot that an item would read, or -1 when it reads none.
  function automatic int entry_needed(req_t it);
    logic [31:0] elapsed;
    logic [7:0]  slot;
    elapsed = it.now_ms - note_t0;
    slot = play_pos + 8'd1;
    if (it.req_type == REQ_START) return 0;
    if (it.req_type != REQ_TIME || !playing || elapsed < {10'd0, note_len}) return -1;
    if (int'(play_pos) + 1 < int'(song_len)) return int'(slot) % NOTE_DEPTH;
    return looping ? 0 : -1;
  endfunction

  function automatic logic [31:0] due_ms();
    return note_t0 + {10'd0, note_len};
  endfunction

  function automatic req_t note_item(logic [7:0] idx, int unsigned p, o, n, d);
    req_t it;
    it.req_type        = REQ_LOAD;
    it.now_ms          = $urandom();
    it.entry_index     = idx;
    it.pitch_code      = p[3:0];
    it.octave_in       = o[3:0];
    it.dur_numerator   = n[4:0];
    it.dur_denominator = d[6:0];
    return it;
  endfunction

  function automatic req_t random_note(logic [7:0] idx);
    if ($urandom_range(0, 9) < 7) begin
      return note_item(idx, $urandom_range(0, 12), $urandom_range(0, 8),
                       $urandom_range(1, 16), $urandom_range(1, 64));
    end
    return note_item(idx, $urandom_range(0, 15), $urandom_range(0, 15),
                     $urandom_range(0, 31), $urandom_range(0, 127));
  endfunction

  // Fields that the operation ignores carry random bits.
  function automatic req_t ctrl_item(logic [1:0] op, logic [31:0] at_ms);
    logic [63:0] noise;
    req_t        it;
    noise = {$urandom(), $urandom()};
    it = noise[$bits(req_t)-1:0];
    it.req_type = op;
    it.now_ms   = at_ms;
    return it;
  endfunction

  function automatic logic [7:0] melody_slot();
    int unsigned span, pick;
    span = (song_len == 0 || song_len > 256) ? 256 : song_len;
    if ($urandom_range(0, 4) == 0) span = 256;
    pick = $urandom_range(0, span - 1);
    return pick[7:0];
  endfunction

  // Mostly lands on or past the end of the current note.
  function automatic logic [31:0] tick_time();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 3) return due_ms();
    if (roll == 3) return due_ms() - ((note_len != 0) ? 32'd1 : 32'd0);
    if (roll == 4) return $urandom();
    if (roll == 5) return note_t0 + ($urandom() % ({10'd0, note_len} + 32'd1));
    return due_ms() + $urandom_range(1, 50);
  endfunction

  // A slot that has never been loaded is filled before anything reads it.
  function automatic void queue_item(req_t it);
    int   need;
    req_t fill;
    need = entry_needed(it);
    if (need >= 0 && !song_loaded[need]) begin
      fill = random_note(need[7:0]);
      melody_exp.push_back(predict(fill));
      pending_items.push_back(fill);
    end
    melody_exp.push_back(predict(it));
    pending_items.push_back(it);
  endfunction

  function automatic void random_items(int count, bit calm);
    int unsigned roll;
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      if (playing) begin
        if (roll < (calm ? 98 : 72)) queue_item(ctrl_item(REQ_TIME, tick_time()));
        else if (calm || roll < 84) queue_item(random_note(melody_slot()));
        else if (roll < 93) queue_item(ctrl_item(REQ_START, $urandom()));
        else queue_item(ctrl_item(REQ_STOP, $urandom()));
      end else begin
        if (roll < (calm ? 80 : 45)) queue_item(ctrl_item(REQ_START, $urandom()));
        else if (calm || roll < 70) queue_item(random_note(melody_slot()));
        else if (roll < 85) queue_item(ctrl_item(REQ_TIME, $urandom()));
        else queue_item(ctrl_item(REQ_STOP, $urandom()));
      end
    end
  endfunction

  task automatic wait_idle();
    while (pending_items.size() != 0 || melody_exp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(logic [1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_W-1:0];
    case (idx)
      CFG_TEMPO:  tempo    = val[9:0];
      CFG_LENGTH: song_len = val[8:0];
      CFG_LOOP:   looping  = val[0];
      default: ;
    endcase
  endtask

  task automatic play_setting(int unsigned bpm, int unsigned notes, int unsigned wrap);
    wait_idle();
    set_reg(CFG_TEMPO, bpm);
    set_reg(CFG_LENGTH, notes);
    set_reg(CFG_LOOP, wrap);
    @(posedge clk);
    cfg_write <= 1'b0;
    settings++;
  endtask

  // Sender: bursts of random length, random gaps between them.
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!req_valid || req_ready) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        req_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        req_item  <= pending_items.pop_front();
        req_valid <= 1'b1;
        sent++;
        if (burst_left > 1) begin
          burst_left = burst_left - 1;
        end else begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Receiver: the stall rate is redrawn at the end of each span of random length.
  int stall_pct  = 0;
  int stall_span = 0;

  always @(posedge clk) begin : result_check
    res_t want;
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        if (melody_exp.size() == 0) begin
          failures++;
          if (failures <= MAX_SHOWN)
            $display("Unexpected result: write=%b silent=%b pitch=%0d oct=%0d play=%b pos=%0d",
                     res_item.tone_write, res_item.tone_silent, res_item.pitch_out,
                     res_item.octave_out, res_item.is_playing, res_item.note_position);
        end else begin
          want = melody_exp.pop_front();
          checked++;
          if (res_item.tone_write    !== want.tone_write  ||
              res_item.tone_silent   !== want.tone_silent ||
              res_item.pitch_out     !== want.pitch_out   ||
              res_item.octave_out    !== want.octave_out  ||
              res_item.is_playing    !== want.is_playing  ||
              res_item.note_position !== want.note_position) begin
            failures++;
            if (failures <= MAX_SHOWN) begin
              $display("Result %0d mismatch at cycle %0d", checked, cycle_count);
              $display("  expected write=%b silent=%b pitch=%0d oct=%0d play=%b pos=%0d",
                       want.tone_write, want.tone_silent, want.pitch_out,
                       want.octave_out, want.is_playing, want.note_position);
              $display("  actual   write=%b silent=%b pitch=%0d oct=%0d play=%b pos=%0d",
                       res_item.tone_write, res_item.tone_silent, res_item.pitch_out,
                       res_item.octave_out, res_item.is_playing, res_item.note_position);
            end
          end
        end
      end
      if (stall_span == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 30;
          2: stall_pct = 70;
          default: stall_pct = 90;
        endcase
        stall_span = $urandom_range(50, 300);
      end else begin
        stall_span = stall_span - 1;
      end
      res_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= LIMIT);
    $display("Timeout after %0d cycles with %0d results outstanding", LIMIT,
             melody_exp.size());
    $display("** melody_note_sequencer: FAILED **");
    $finish;
  end

  initial begin : stimulus
    bit calm;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: tempo 120, one note, no looping.
    queue_item(note_item(8'd0, 0, 0, 1, 4));
    queue_item(note_item(8'd1, 11, 8, 16, 64));
    queue_item(note_item(8'd2, REST_CODE, 3, 0, 0));
    queue_item(note_item(8'd255, 15, 15, 31, 127));
    queue_item(ctrl_item(REQ_TIME, 32'd0));
    queue_item(ctrl_item(REQ_STOP, 32'hFFFF_FFFF));
    queue_item(ctrl_item(REQ_START, 32'hFFFF_FF00));
    queue_item(ctrl_item(REQ_TIME, due_ms() - 32'd1));
    queue_item(ctrl_item(REQ_TIME, due_ms()));
    queue_item(ctrl_item(REQ_TIME, due_ms() + 32'd5));
    queue_item(ctrl_item(REQ_START, 32'd7));
    queue_item(ctrl_item(REQ_START, 32'd9));
    queue_item(ctrl_item(REQ_STOP, 32'd11));

    // Fastest tempo with a three note loop; the last note is a zero-length rest.
    play_setting(1023, 3, 1);
    queue_item(note_item(8'd0, 5, 9, 31, 1));
    queue_item(ctrl_item(REQ_START, 32'd0));
    queue_item(ctrl_item(REQ_TIME, due_ms()));
    queue_item(ctrl_item(REQ_TIME, due_ms()));
    queue_item(ctrl_item(REQ_TIME, due_ms()));
    queue_item(ctrl_item(REQ_STOP, 32'd1));

    // Zero tempo, zero melody length: the note length saturates.
    play_setting(0, 0, 0);
    queue_item(note_item(8'd0, 0, 0, 31, 1));
    queue_item(ctrl_item(REQ_START, 32'd5));
    queue_item(ctrl_item(REQ_TIME, due_ms()));

    for (int ph = 0; ph < 8; ph++) begin
      calm = (ph == 1 || ph == 3);
      case (ph)
        0: play_setting(240, 4, 1);
        1: play_setting(1, 256, 1);
        2: play_setting(1023, 1, 1);
        3: play_setting($urandom_range(1, 1023), 300, 1);
        4: play_setting($urandom_range(1, 1023), $urandom_range(1, 16), $urandom_range(0, 1));
        5: play_setting(77, 0, 1);
        6: play_setting($urandom_range(1, 1023), $urandom_range(2, 8), 0);
        default: play_setting($urandom_range(1, 1023), 511, 1);
      endcase
      random_items(calm ? 320 : 130, calm);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d items: %0d note loads, %0d starts, %0d note changes, %0d melody ends,",
             sent, loads, starts, advances, song_ends);
    $display("over %0d register settings; %0d results checked, %0d mismatches.",
             settings, checked, failures);
    if (failures == 0 && melody_exp.size() == 0) begin
      $display("** melody_note_sequencer: PASSED **");
    end else begin
      $display("** melody_note_sequencer: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/msq_pkg.sv
src/msq_ram.sv
src/msq_div.sv
src/melody_note_sequencer.sv
bench/tb_melody_note_sequencer.sv
